FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gbee_pkg.sv
package gbee_pkg;

  localparam int unsigned NumBindings = 12;
  localparam logic [14:0] ThrReset = 15'd9000;
  localparam logic [14:0] DzReset = 15'd7849;
  localparam logic [15:0] Q15One = 16'd32767;

  typedef enum logic [1:0] {
    KIND_KEY = 2'd0,
    KIND_LOST = 2'd1,
    KIND_STICK = 2'd2
  } kind_t;

  localparam logic [0:0] RegThr = 1'b0;
  localparam logic [0:0] RegDz = 1'b1;

  typedef struct packed {
    logic connected;
    logic [15:0] buttons;
    logic signed [15:0] stick_x_raw;
    logic signed [15:0] stick_y_raw;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] key_index;
    logic pressed;
    logic signed [15:0] stick_x_norm;
    logic signed [15:0] stick_y_norm;
    logic last;
  } out_item_t;

  // Bit position in the raw mask of each binding, in scan order.
  function automatic logic [3:0] bind_bit(input logic [3:0] idx);
    logic [3:0] b;
    b = 4'd0;
    case (idx)
      4'd0: b = 4'd12;
      4'd1: b = 4'd13;
      4'd2: b = 4'd14;
      4'd3: b = 4'd15;
      4'd4: b = 4'd8;
      4'd5: b = 4'd9;
      4'd6: b = 4'd5;
      4'd7: b = 4'd4;
      4'd8: b = 4'd0;
      4'd9: b = 4'd1;
      4'd10: b = 4'd2;
      4'd11: b = 4'd3;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

endpackage

FILE: src/gbee_norm.sv
// Radial dead zone stick normalization. One bit of each result per cycle:
// a shift-and-add squarer, a bit-serial square root, and restoring dividers.
module gbee_norm (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [15:0] x_in,
  input  logic signed [15:0] y_in,
  input  logic [14:0] dead_zone,
  output logic done,
  output logic signed [15:0] nx,
  output logic signed [15:0] ny
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_CHK, S_SQRT, S_RDIV, S_MUL, S_ODIV, S_NEXT, S_DONE
  } state_t;

  localparam logic [15:0] Q15 = 16'd32767;

  state_t state_r;
  logic [5:0] cnt_r;
  logic [15:0] ax_r, ay_r;
  logic sx_r, sy_r;
  logic [31:0] s_r;
  logic [47:0] rem_r;
  logic [47:0] rad_r;
  logic [24:0] root_r;
  logic [24:0] num_r, den_r;
  logic [15:0] r_r;
  logic [39:0] prod_r;
  logic [15:0] mulb_r;
  logic axis_r;
  logic signed [15:0] nx_r, ny_r;
  logic done_r;
  logic [15:0] qout_r;

  logic [15:0] cx_mag, cy_mag;
  logic [25:0] sq_trial;
  logic [48:0] div_trial;
  logic [29:0] dzsq;
  logic [15:0] qsat;

  always_comb begin
    cx_mag = x_in[15] ? ((x_in == 16'sh8000) ? 16'd32767 : 16'(-x_in)) : x_in;
    cy_mag = y_in[15] ? ((y_in == 16'sh8000) ? 16'd32767 : 16'(-y_in)) : y_in;
    sq_trial = {rem_r[47:24], rad_r[47:46]} - {root_r[23:0], 2'b01};
    div_trial = {rem_r, rad_r[39]} - {24'd0, den_r};
    dzsq = 30'(dead_zone) * 30'(dead_zone);
    qsat = (qout_r > Q15) ? Q15 : qout_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            ax_r <= cx_mag; ay_r <= cy_mag;
            sx_r <= x_in[15]; sy_r <= y_in[15];
            s_r <= '0; prod_r <= '0;
            mulb_r <= cx_mag; cnt_r <= '0;
            nx_r <= '0; ny_r <= '0;
            state_r <= S_SQX;
          end
        end
        // Squares are built one multiplier bit per cycle.
        S_SQX, S_SQY: begin
          if (mulb_r[cnt_r[3:0]])
            s_r <= s_r + ({16'd0, (state_r == S_SQX) ? ax_r : ay_r} << cnt_r[3:0]);
          if (cnt_r == 6'd15) begin
            cnt_r <= '0;
            mulb_r <= ay_r;
            state_r <= (state_r == S_SQX) ? S_SQY : S_CHK;
          end else cnt_r <= cnt_r + 6'd1;
        end
        S_CHK: begin
          if ({2'b0, s_r} <= {4'd0, dzsq}) state_r <= S_DONE;
          else begin
            rad_r <= {s_r, 16'd0};
            rem_r <= '0; root_r <= '0; cnt_r <= '0;
            state_r <= S_SQRT;
          end
        end
        // Square root of s*65536, two radicand bits per cycle.
        S_SQRT: begin
          if (!sq_trial[25]) begin
            rem_r <= {sq_trial[23:0], 24'd0};
            root_r <= {root_r[23:0], 1'b1};
          end else begin
            rem_r <= {rem_r[45:24], rad_r[47:46], 24'd0};
            root_r <= {root_r[23:0], 1'b0};
          end
          rad_r <= {rad_r[45:0], 2'b00};
          if (cnt_r == 6'd23) begin
            cnt_r <= '0;
            state_r <= S_RDIV;
          end else cnt_r <= cnt_r + 6'd1;
        end
        // r = (m8 - dz*256) * 32767 / ((32767 - dz) * 256), restoring.
        S_RDIV: begin
          if (cnt_r == 6'd0) begin
            num_r <= (root_r > {2'd0, dead_zone, 8'd0}) ?
                     root_r - {2'd0, dead_zone, 8'd0} : '0;
            den_r <= {2'd0, 15'(Q15 - {1'b0, dead_zone}), 8'd0};
            prod_r <= '0; mulb_r <= Q15;
            cnt_r <= 6'd1;
          end else if (cnt_r <= 6'd15) begin
            if (mulb_r[cnt_r[3:0] - 4'd1])
              prod_r <= prod_r + ({15'd0, num_r} << (cnt_r[3:0] - 4'd1));
            cnt_r <= cnt_r + 6'd1;
          end else if (cnt_r == 6'd16) begin
            rem_r <= '0; rad_r <= {8'd0, prod_r};
            cnt_r <= 6'd17;
          end else if (cnt_r == 6'd57) begin
            // All forty quotient bits are in by now.
            if (den_r == '0) r_r <= Q15;
            else r_r <= qsat;
            axis_r <= 1'b0; cnt_r <= '0;
            state_r <= S_MUL;
          end else begin
            if (!div_trial[48]) rem_r <= div_trial[47:0];
            else rem_r <= {rem_r[46:0], rad_r[39]};
            rad_r <= {rad_r[46:0], 1'b0};
            cnt_r <= cnt_r + 6'd1;
          end
        end
        // Product |c| * r * 256 one bit per cycle, then divide by m8.
        S_MUL: begin
          if (cnt_r == 6'd0) begin
            prod_r <= '0;
            mulb_r <= axis_r ? ay_r : ax_r;
            cnt_r <= 6'd1;
          end else begin
            if (mulb_r[cnt_r[3:0] - 4'd1])
              prod_r <= prod_r + ({24'd0, r_r} << (cnt_r + 6'd7));
            if (cnt_r == 6'd16) begin
              cnt_r <= '0;
              state_r <= S_ODIV;
            end else cnt_r <= cnt_r + 6'd1;
          end
        end
        S_ODIV: begin
          if (cnt_r == 6'd0) begin
            rem_r <= '0; rad_r <= {8'd0, prod_r}; den_r <= root_r;
            cnt_r <= 6'd1;
          end else begin
            if (!div_trial[48]) rem_r <= div_trial[47:0];
            else rem_r <= {rem_r[46:0], rad_r[39]};
            rad_r <= {rad_r[46:0], 1'b0};
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'd40) state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (axis_r) begin
            ny_r <= sy_r ? 16'(-qsat) : qsat;
            state_r <= S_DONE;
          end else begin
            nx_r <= sx_r ? 16'(-qsat) : qsat;
            axis_r <= 1'b1; cnt_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_DONE: begin
          done_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Quotient bits collect alongside the restoring steps.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) qout_r <= '0;
    else if (((state_r == S_RDIV) && (cnt_r >= 6'd17) && (cnt_r <= 6'd56)) ||
             ((state_r == S_ODIV) && (cnt_r != 6'd0))) begin
      qout_r <= qout_r[15] ? 16'hFFFF : {qout_r[14:0], !div_trial[48]};
    end else if ((state_r == S_MUL) || (state_r == S_NEXT)) qout_r <= '0;
  end

  assign done = done_r;
  assign nx = nx_r;
  assign ny = ny_r;

endmodule

FILE: src/gamepad_button_edge_events_top.sv
// Key events come first, one per cycle while the output is taken, and the
// stick summary ends each poll. A new request is accepted only in idle, so a
// connected poll runs through the bit-serial square root and the three
// restoring divisions in gbee_norm before the next; a disconnected poll goes
// through the device-lost result, if a device was connected, to the summary.
// Reset (rst_n low, synchronous) restores both registers to their defaults
// and clears the remembered buttons and the connected flag.
`include "assert_macros.svh"
module gamepad_button_edge_events_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  gbee_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output gbee_pkg::out_item_t out_data,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOST, S_SCAN, S_WAIT, S_SUM, S_DRAIN
  } state_t;

  state_t state_r;
  logic [14:0] thr_r, dz_r;
  logic [11:0] prev_r;
  logic conn_r;
  logic [15:0] btn_r;
  logic [3:0] idx_r;
  logic out_valid_r;
  gbee_pkg::out_item_t out_r;
  logic norm_start;
  logic norm_done;
  logic norm_ready_r;
  logic signed [15:0] norm_x, norm_y;
  logic [15:0] btn_dir;
  logic now_bit, was_bit;
  logic wr_en;
  logic slot_free;
  logic out_load;
  logic signed [16:0] thr_s;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = cfg_paddr[2] ? {17'd0, dz_r} : {17'd0, thr_r};

  always_comb begin
    thr_s = {2'b00, thr_r};
    btn_dir = in_data.buttons;
    if (17'(in_data.stick_x_raw) < -thr_s) btn_dir[2] = 1'b1;
    else if (17'(in_data.stick_x_raw) > thr_s) btn_dir[3] = 1'b1;
    if (17'(in_data.stick_y_raw) < -thr_s) btn_dir[1] = 1'b1;
    else if (17'(in_data.stick_y_raw) > thr_s) btn_dir[0] = 1'b1;
    now_bit = btn_r[gbee_pkg::bind_bit(idx_r)];
    was_bit = prev_r[idx_r];
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  // The normalizer takes the stick straight from the accepted request.
  assign norm_start = in_valid && in_ready && in_data.connected;
  assign out_load = slot_free && ((state_r == S_LOST) || (state_r == S_DRAIN) ||
                    (state_r == S_SUM) || ((state_r == S_SCAN) && (now_bit != was_bit)));

  gbee_norm u_norm (
    .clk(clk), .rst_n(rst_n), .start(norm_start),
    .x_in(in_data.stick_x_raw), .y_in(in_data.stick_y_raw),
    .dead_zone(dz_r), .done(norm_done), .nx(norm_x), .ny(norm_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= gbee_pkg::ThrReset;
      dz_r <= gbee_pkg::DzReset;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        gbee_pkg::RegThr: thr_r <= cfg_pwdata[14:0];
        gbee_pkg::RegDz: dz_r <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prev_r <= '0;
      conn_r <= 1'b0;
      out_valid_r <= 1'b0;
      norm_ready_r <= 1'b0;
      idx_r <= '0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      // The done pulse is held until the scan has finished.
      norm_ready_r <= (norm_ready_r || norm_done) && (state_r != S_WAIT);
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            idx_r <= '0;
            btn_r <= btn_dir;
            if (!in_data.connected) begin
              state_r <= conn_r ? S_LOST : S_SUM;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_LOST: begin
          if (slot_free) begin
            out_r <= '{event_kind: gbee_pkg::KIND_LOST, default: '0};
            state_r <= S_SUM;
          end
        end
        S_SCAN: begin
          if (now_bit == was_bit || slot_free) begin
            if (now_bit != was_bit) begin
              out_r <= '{event_kind: gbee_pkg::KIND_KEY, key_index: idx_r,
                         pressed: now_bit, default: '0};
            end
            prev_r[idx_r] <= now_bit;
            if (idx_r == 4'(gbee_pkg::NumBindings - 1)) state_r <= S_WAIT;
            idx_r <= idx_r + 4'd1;
          end
        end
        S_WAIT: begin
          if (norm_ready_r || norm_done) begin
            conn_r <= 1'b1;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (slot_free) begin
            out_r <= '{event_kind: gbee_pkg::KIND_STICK, stick_x_norm: norm_x,
                       stick_y_norm: norm_y, last: 1'b1, default: '0};
            state_r <= S_IDLE;
          end
        end
        S_SUM: begin
          if (slot_free) begin
            out_r <= '{event_kind: gbee_pkg::KIND_STICK, last: 1'b1, default: '0};
            prev_r <= '0;
            conn_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  `ASSERT_IMPL(a_last_is_sum, out_valid && out_data.last,
    out_data.event_kind == gbee_pkg::KIND_STICK, "last result is not a summary")
  `ASSERT_IMPL(a_key_range, out_valid && out_data.event_kind == gbee_pkg::KIND_KEY,
    out_data.key_index < 4'(gbee_pkg::NumBindings), "key index out of range")
  `ASSERT_NEXT(a_lost_clears, state_r == S_SUM && slot_free,
    !conn_r && prev_r == 12'd0, "disconnect left state behind")

endmodule
